// ===== hdl/weo_pkg.sv =====
// Shared definitions for the wheel encoder odometry block.
// Field widths, register indexes, fixed-point constants, command and status types.
// No dependencies.
`default_nettype none

package weo_pkg;

	localparam int WHEELS_DEF = 4;

	localparam int STAMP_W    = 48;
	localparam int STEP_W     = 32;
	localparam int RATE_W     = 32;
	localparam int CNT_W      = 48;
	localparam int SPD_W      = 32;
	localparam int TRAV_W     = 64;
	localparam int CPR_W      = 20;
	localparam int RAD_W      = 18;
	localparam int MASK_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_CPR    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASK   = 2'd2;

	localparam logic [CPR_W-1:0]  CPR_RST    = 20'd1024;
	localparam logic [RAD_W-1:0]  RADIUS_RST = 18'd19661;
	localparam logic [MASK_W-1:0] MASK_RST   = 4'hF;

	// 1/(2 pi) in Q0.32 and 2 pi in Q3.29
	localparam logic [29:0] INV_TWO_PI = 30'd683565276;
	localparam logic [31:0] TWO_PI     = 32'd3373259426;
	localparam logic [47:0] COUNT_CAP  = 48'h7FFF_FFFF_FFFF;
	localparam logic [59:0] DIST_CAP   = 60'd576460752303423488;

	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_NONE  = 5'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 5'd1;
	localparam logic [OP_W-1:0] OP_KA    = 5'd2;
	localparam logic [OP_W-1:0] OP_KB    = 5'd3;
	localparam logic [OP_W-1:0] OP_KC    = 5'd4;
	localparam logic [OP_W-1:0] OP_MUL   = 5'd5;
	localparam logic [OP_W-1:0] OP_ACC   = 5'd6;
	localparam logic [OP_W-1:0] OP_RATE  = 5'd7;
	localparam logic [OP_W-1:0] OP_ANG   = 5'd8;
	localparam logic [OP_W-1:0] OP_CNT   = 5'd9;
	localparam logic [OP_W-1:0] OP_DSPD  = 5'd10;
	localparam logic [OP_W-1:0] OP_DSTEP = 5'd11;
	localparam logic [OP_W-1:0] OP_SPD   = 5'd12;
	localparam logic [OP_W-1:0] OP_DDST  = 5'd13;
	localparam logic [OP_W-1:0] OP_DIST  = 5'd14;
	localparam logic [OP_W-1:0] OP_DMEAN = 5'd15;
	localparam logic [OP_W-1:0] OP_MEAN  = 5'd16;
	localparam logic [OP_W-1:0] OP_VSPD  = 5'd17;
	localparam logic [OP_W-1:0] OP_DTOT  = 5'd18;
	localparam logic [OP_W-1:0] OP_TOT   = 5'd19;
	localparam logic [OP_W-1:0] OP_OUT   = 5'd20;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [1:0]      ia;
		logic            ib;
		logic [1:0]      sh;
	} cmd_t;

	typedef struct packed {
		logic bad;
		logic none_used;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== hdl/wheel_encoder_odometry_top.sv =====
// Top level of the wheel encoder odometry block.
// Joins the sequencer and the datapath; holds the interface assertions.
// Depends on weo_pkg, weo_ctrl, weo_dp.
`default_nettype none

// Wheel encoder odometry. Each input transfer carries a time stamp, a step
// length and one angular rate per wheel; each produces exactly one output
// transfer with the total encoder counts, quantised wheel speeds, vehicle
// speed and travelled distance. Items are processed one at a time through
// the shared radix-2 divider, which runs two 64-step divisions per wheel and
// two more for the averages when any wheel is selected, and the shared 32x32
// multiplier, whose partial products are summed in an accumulator. A zero
// step length skips the computation and returns a result with m_tuser set.
// The next item is taken while a result waits on m_tready. Configuration
// writes are always accepted and must only be issued while the block is
// idle.
module wheel_encoder_odometry_top #(
	parameter int WHEELS = weo_pkg::WHEELS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// stamp, step_length, rate_wheel0 .. rate_wheelN
	input  wire logic [80+32*WHEELS-1:0]         s_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// stamp_out, count_wheel0 .. N, speed_wheel0 .. N, vehicle_speed, travelled
	output logic [144+80*WHEELS-1:0]             m_tdata,
	// bad_step
	output logic                                 m_tuser,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [weo_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [weo_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import weo_pkg::*;

	localparam int WIDX = (WHEELS > 1) ? $clog2(WHEELS) : 1;

	cmd_t            cmd;
	sts_t            sts;
	logic [WIDX-1:0] wheel;

	weo_ctrl #(.WHEELS(WHEELS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd),
		.wheel    (wheel)
	);

	weo_dp #(.WHEELS(WHEELS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.wheel     (wheel),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	assign cfg_ready = 1'b1;

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again straight after a transfer");

	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_OUT |-> (!m_tvalid || m_tready))
		else $error("result written over a pending transfer");

	a_bad_step_zero_speed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[48+80*WHEELS +: 32] == '0)
		else $error("bad step result carries a vehicle speed");

endmodule

`default_nettype wire

// ===== hdl/weo_ctrl.sv =====
// Sequencer for the wheel encoder odometry block.
// Steps the datapath through multiply, divide and update phases per wheel.
// Depends on weo_pkg.
`default_nettype none

module weo_ctrl #(
	parameter int WHEELS = weo_pkg::WHEELS_DEF,
	localparam int WIDX = (WHEELS > 1) ? $clog2(WHEELS) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire weo_pkg::sts_t sts,
	output weo_pkg::cmd_t      cmd,
	output logic [WIDX-1:0]    wheel
);
	import weo_pkg::*;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_CHK   = 5'd1;
	localparam logic [4:0] S_KA    = 5'd2;
	localparam logic [4:0] S_KB    = 5'd3;
	localparam logic [4:0] S_KC    = 5'd4;
	localparam logic [4:0] S_RATE  = 5'd5;
	localparam logic [4:0] S_ANG   = 5'd6;
	localparam logic [4:0] S_CNT   = 5'd7;
	localparam logic [4:0] S_DSPD  = 5'd8;
	localparam logic [4:0] S_SPD   = 5'd9;
	localparam logic [4:0] S_DDST  = 5'd10;
	localparam logic [4:0] S_DIST  = 5'd11;
	localparam logic [4:0] S_FIN   = 5'd12;
	localparam logic [4:0] S_DMEAN = 5'd13;
	localparam logic [4:0] S_MEAN  = 5'd14;
	localparam logic [4:0] S_VSPD  = 5'd15;
	localparam logic [4:0] S_DTOT  = 5'd16;
	localparam logic [4:0] S_TOT   = 5'd17;
	localparam logic [4:0] S_OUT   = 5'd18;
	localparam logic [4:0] S_MUL   = 5'd19;
	localparam logic [4:0] S_ACC   = 5'd20;
	localparam logic [4:0] S_DIV   = 5'd21;

	localparam logic [2:0] MK_K1   = 3'd0;
	localparam logic [2:0] MK_K2   = 3'd1;
	localparam logic [2:0] MK_RATE = 3'd2;
	localparam logic [2:0] MK_ANG  = 3'd3;
	localparam logic [2:0] MK_BASE = 3'd4;
	localparam logic [2:0] MK_RAD  = 3'd5;
	localparam logic [2:0] MK_VEH  = 3'd6;

	localparam logic [1:0] DK_SPD  = 2'd0;
	localparam logic [1:0] DK_DST  = 2'd1;
	localparam logic [1:0] DK_MEAN = 2'd2;
	localparam logic [1:0] DK_TOT  = 2'd3;

	logic [4:0]      state_q, state_d;
	logic [2:0]      mk_q, mk_d;
	logic [1:0]      dk_q, dk_d;
	logic [1:0]      pc_q, pc_d;
	logic [5:0]      dc_q, dc_d;
	logic [WIDX-1:0] wheel_q, wheel_d;

	logic [1:0] sc_ia;
	logic       sc_ib;
	logic [1:0] sc_sh;
	logic [1:0] sc_last;
	logic [4:0] mul_next;
	logic [4:0] div_next;

	always_comb begin
		sc_ia   = 2'd0;
		sc_ib   = 1'b0;
		sc_sh   = 2'd0;
		sc_last = 2'd0;
		unique case (mk_q)
			MK_ANG: begin
				sc_ia   = {1'b0, pc_q[1]};
				sc_ib   = pc_q[0];
				sc_sh   = {1'b0, pc_q[1]} + {1'b0, pc_q[0]};
				sc_last = 2'd3;
			end
			MK_BASE: begin
				sc_ia   = pc_q;
				sc_sh   = pc_q;
				sc_last = 2'd1;
			end
			MK_RAD: begin
				sc_ia   = pc_q;
				sc_sh   = pc_q;
				sc_last = 2'd2;
			end
			default: ;
		endcase
	end

	always_comb begin
		unique case (mk_q)
			MK_K1:   mul_next = S_KB;
			MK_K2:   mul_next = S_KC;
			MK_RATE: mul_next = S_ANG;
			MK_ANG:  mul_next = S_CNT;
			MK_BASE: mul_next = S_DSPD;
			MK_RAD:  mul_next = S_DDST;
			MK_VEH:  mul_next = S_VSPD;
			default: mul_next = S_IDLE;
		endcase
		unique case (dk_q)
			DK_SPD:  div_next = S_SPD;
			DK_DST:  div_next = S_DIST;
			DK_MEAN: div_next = S_MEAN;
			DK_TOT:  div_next = S_TOT;
			default: div_next = S_IDLE;
		endcase
	end

	always_comb begin
		state_d = state_q;
		mk_d    = mk_q;
		dk_d    = dk_q;
		pc_d    = pc_q;
		dc_d    = dc_q;
		wheel_d = wheel_q;
		cmd     = '0;
		cmd.op  = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				wheel_d = '0;
				state_d = sts.bad ? S_OUT : S_KA;
			end
			S_KA: begin
				cmd.op  = OP_KA;
				mk_d    = MK_K1;
				pc_d    = 2'd0;
				state_d = S_MUL;
			end
			S_KB: begin
				cmd.op  = OP_KB;
				mk_d    = MK_K2;
				pc_d    = 2'd0;
				state_d = S_MUL;
			end
			S_KC: begin
				cmd.op  = OP_KC;
				state_d = S_RATE;
			end
			S_RATE: begin
				cmd.op  = OP_RATE;
				mk_d    = MK_RATE;
				pc_d    = 2'd0;
				state_d = S_MUL;
			end
			S_ANG: begin
				cmd.op  = OP_ANG;
				mk_d    = MK_ANG;
				pc_d    = 2'd0;
				state_d = S_MUL;
			end
			S_CNT: begin
				cmd.op  = OP_CNT;
				mk_d    = MK_BASE;
				pc_d    = 2'd0;
				state_d = S_MUL;
			end
			S_DSPD: begin
				cmd.op  = OP_DSPD;
				dk_d    = DK_SPD;
				dc_d    = 6'd0;
				state_d = S_DIV;
			end
			S_SPD: begin
				cmd.op  = OP_SPD;
				mk_d    = MK_RAD;
				pc_d    = 2'd0;
				state_d = S_MUL;
			end
			S_DDST: begin
				cmd.op  = OP_DDST;
				dk_d    = DK_DST;
				dc_d    = 6'd0;
				state_d = S_DIV;
			end
			S_DIST: begin
				cmd.op = OP_DIST;
				if (wheel_q == WIDX'(WHEELS - 1)) begin
					state_d = S_FIN;
				end else begin
					wheel_d = wheel_q + 1'b1;
					state_d = S_RATE;
				end
			end
			S_FIN: begin
				state_d = sts.none_used ? S_OUT : S_DMEAN;
			end
			S_DMEAN: begin
				cmd.op  = OP_DMEAN;
				dk_d    = DK_MEAN;
				dc_d    = 6'd0;
				state_d = S_DIV;
			end
			S_MEAN: begin
				cmd.op  = OP_MEAN;
				mk_d    = MK_VEH;
				pc_d    = 2'd0;
				state_d = S_MUL;
			end
			S_VSPD: begin
				cmd.op  = OP_VSPD;
				state_d = S_DTOT;
			end
			S_DTOT: begin
				cmd.op  = OP_DTOT;
				dk_d    = DK_TOT;
				dc_d    = 6'd0;
				state_d = S_DIV;
			end
			S_TOT: begin
				cmd.op  = OP_TOT;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			S_MUL: begin
				cmd.op  = OP_MUL;
				cmd.ia  = sc_ia;
				cmd.ib  = sc_ib;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.op = OP_ACC;
				cmd.sh = sc_sh;
				if (pc_q == sc_last) begin
					state_d = mul_next;
				end else begin
					pc_d    = pc_q + 2'd1;
					state_d = S_MUL;
				end
			end
			S_DIV: begin
				cmd.op = OP_DSTEP;
				dc_d   = dc_q + 6'd1;
				if (dc_q == 6'd63) begin
					state_d = div_next;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mk_q    <= MK_K1;
			dk_q    <= DK_SPD;
			pc_q    <= 2'd0;
			dc_q    <= 6'd0;
			wheel_q <= '0;
		end else begin
			state_q <= state_d;
			mk_q    <= mk_d;
			dk_q    <= dk_d;
			pc_q    <= pc_d;
			dc_q    <= dc_d;
			wheel_q <= wheel_d;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign wheel    = wheel_q;

endmodule

`default_nettype wire

// ===== hdl/weo_dp.sv =====
// Datapath of the wheel encoder odometry block: registers, wheel state,
// shared 32x32 multiplier with accumulator, radix-2 divider, output register.
// Depends on weo_pkg.
`default_nettype none

module weo_dp #(
	parameter int WHEELS = weo_pkg::WHEELS_DEF,
	localparam int WIDX = (WHEELS > 1) ? $clog2(WHEELS) : 1,
	localparam int IN_W = 80 + 32 * WHEELS,
	localparam int OUT_W = 144 + 80 * WHEELS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire weo_pkg::cmd_t               cmd,
	input  wire logic [WIDX-1:0]             wheel,
	output weo_pkg::sts_t                    sts,
	input  wire logic [IN_W-1:0]             s_tdata,
	input  wire logic                        cfg_valid,
	input  wire logic [weo_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [weo_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [OUT_W-1:0]                 m_tdata,
	output logic                             m_tuser
);
	import weo_pkg::*;

	localparam logic [63:0] A_MAX = {1'b0, {63{1'b1}}};
	localparam logic [64:0] A_HI  = {2'b00, {63{1'b1}}};
	localparam logic [64:0] A_LO  = {2'b11, 62'd0, 1'b1};
	localparam logic [64:0] T_LO  = {2'b11, 63'd0};

	logic [CPR_W-1:0]  cpr_q;
	logic [RAD_W-1:0]  rad_q;
	logic [MASK_W-1:0] mask_q;
	logic [63:0]       angle_q [WHEELS];
	logic [CNT_W-1:0]  last_q  [WHEELS];
	logic [63:0]       total_q;
	logic              out_valid_q;
	logic              bad_q;

	logic [STAMP_W-1:0] stamp_q;
	logic [STEP_W-1:0]  step_q;
	logic [RATE_W-1:0]  rate_q [WHEELS];
	logic [49:0]        k_q;
	logic [51:0]        cs_q;
	logic [95:0]        opa_q;
	logic [63:0]        opb_q;
	logic [63:0]        pp_q;
	logic [127:0]       acc_q;
	logic [63:0]        rem_q, quo_q, nlo_q, dv_q;
	logic               dsat_q;
	logic               rneg_q, aneg_q, dneg_q;
	logic [80:0]        base_q;
	logic [35:0]        sum_spd_q;
	logic [63:0]        sum_dist_q;
	logic [2:0]         used_q;
	logic [CNT_W-1:0]   cnt_res_q [WHEELS];
	logic [SPD_W-1:0]   spd_res_q [WHEELS];
	logic [SPD_W-1:0]   vsp_res_q;
	logic [OUT_W-1:0]   out_data_q;
	logic               out_user_q;

	logic [CPR_W-1:0] cpr_eff;
	logic [WHEELS-1:0] sel_v;
	logic             sel_w;
	logic [31:0]      raw, rmag;
	logic [31:0]      a_ch, b_ch;
	logic [64:0]      inc65, asum65;
	logic [63:0]      ang_new, ang_mag;
	logic [63:0]      chi;
	logic [47:0]      cmag, cnt_new;
	logic [48:0]      delta49, dmag;
	logic [127:0]     spd_num;
	logic [63:0]      qv;
	logic [SPD_W-1:0] spd_new;
	logic [59:0]      dq;
	logic [63:0]      dist_new;
	logic [64:0]      t65;
	logic             ge;
	logic [35:0]      smag;
	logic [63:0]      dtmag;
	logic [47:0]      vm;
	logic [SPD_W-1:0] vsp_new;
	logic [64:0]      tinc65, tsum65;
	logic [63:0]      total_new;
	logic [63:0]      dn_hi, dn_lo, dn_d;
	logic             dstart;
	logic [OUT_W-1:0] odata;

	for (genvar i = 0; i < WHEELS; i++) begin : g_sel
		if (i < MASK_W) begin : g_in
			assign sel_v[i] = mask_q[i];
		end else begin : g_out
			assign sel_v[i] = 1'b0;
		end
	end

	always_comb begin
		cpr_eff = (cpr_q == '0) ? CPR_W'(1) : cpr_q;
		sel_w   = sel_v[wheel];

		raw  = rate_q[wheel];
		rmag = raw[31] ? (32'd0 - raw) : raw;

		a_ch = opa_q[32*cmd.ia +: 32];
		b_ch = opb_q[32*cmd.ib +: 32];

		inc65 = {17'd0, pp_q[63:16]};
		if (rneg_q) begin
			inc65 = 65'd0 - inc65;
		end
		asum65 = {angle_q[wheel][63], angle_q[wheel]} + inc65;
		if ($signed(asum65) > $signed(A_HI)) begin
			ang_new = A_MAX;
		end else if ($signed(asum65) < $signed(A_LO)) begin
			ang_new = A_LO[63:0];
		end else begin
			ang_new = asum65[63:0];
		end
		ang_mag = ang_new[63] ? (64'd0 - ang_new) : ang_new;

		chi     = acc_q[127:64];
		cmag    = (chi > {16'd0, COUNT_CAP}) ? COUNT_CAP : chi[47:0];
		cnt_new = aneg_q ? (48'd0 - cmag) : cmag;
		delta49 = {cnt_new[47], cnt_new} - {last_q[wheel][47], last_q[wheel]};
		dmag    = delta49[48] ? (49'd0 - delta49) : delta49;

		spd_num = {47'd0, acc_q[80:0]} << 19;

		qv = dsat_q ? {64{1'b1}} : quo_q;
		if (dneg_q) begin
			spd_new = (qv >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - qv[31:0]);
		end else begin
			spd_new = (qv >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : qv[31:0];
		end
		dq       = (qv > {4'd0, DIST_CAP}) ? DIST_CAP : qv[59:0];
		dist_new = dneg_q ? (64'd0 - {4'd0, dq}) : {4'd0, dq};

		t65 = {rem_q, nlo_q[63]};
		ge  = (t65 >= {1'b0, dv_q});

		smag  = sum_spd_q[35] ? (36'd0 - sum_spd_q) : sum_spd_q;
		dtmag = sum_dist_q[63] ? (64'd0 - sum_dist_q) : sum_dist_q;

		vm = pp_q[63:16];
		if (sum_spd_q[35]) begin
			vsp_new = (vm >= 48'h8000_0000) ? 32'h8000_0000 : (32'd0 - vm[31:0]);
		end else begin
			vsp_new = (vm > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : vm[31:0];
		end

		tinc65 = {1'b0, quo_q};
		if (sum_dist_q[63]) begin
			tinc65 = 65'd0 - tinc65;
		end
		tsum65 = {total_q[63], total_q} + tinc65;
		if ($signed(tsum65) > $signed(A_HI)) begin
			total_new = A_MAX;
		end else if ($signed(tsum65) < $signed(T_LO)) begin
			total_new = T_LO[63:0];
		end else begin
			total_new = tsum65[63:0];
		end

		dstart = 1'b1;
		dn_hi  = 64'd0;
		dn_lo  = 64'd0;
		dn_d   = 64'd1;
		unique case (cmd.op)
			OP_DSPD: begin
				dn_hi = spd_num[127:64];
				dn_lo = spd_num[63:0];
				dn_d  = {12'd0, cs_q};
			end
			OP_DDST: begin
				dn_hi = acc_q[127:64];
				dn_lo = acc_q[63:0];
				dn_d  = {15'd0, cpr_eff, 29'd0};
			end
			OP_DMEAN: begin
				dn_lo = {28'd0, smag};
				dn_d  = {61'd0, used_q};
			end
			OP_DTOT: begin
				dn_lo = dtmag;
				dn_d  = {61'd0, used_q};
			end
			default: dstart = 1'b0;
		endcase

		odata = '0;
		odata[47:0] = stamp_q;
		for (int i = 0; i < WHEELS; i++) begin
			odata[48 + 48*i +: 48]          = cnt_res_q[i];
			odata[48 + 48*WHEELS + 32*i +: 32] = spd_res_q[i];
		end
		odata[48 + 80*WHEELS +: 32] = vsp_res_q;
		odata[80 + 80*WHEELS +: 64] = total_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q       <= CPR_RST;
			rad_q       <= RADIUS_RST;
			mask_q      <= MASK_RST;
			total_q     <= 64'd0;
			out_valid_q <= 1'b0;
			bad_q       <= 1'b0;
			for (int i = 0; i < WHEELS; i++) begin
				angle_q[i] <= 64'd0;
				last_q[i]  <= '0;
			end
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_CPR:    cpr_q  <= cfg_data;
					REG_RADIUS: rad_q  <= cfg_data[RAD_W-1:0];
					REG_MASK:   mask_q <= cfg_data[MASK_W-1:0];
					default: ;
				endcase
			end
			if (cmd.op == OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (cmd.op)
				OP_LOAD: bad_q <= (s_tdata[79:48] == '0);
				OP_ANG:  angle_q[wheel] <= ang_new;
				OP_CNT:  last_q[wheel] <= cnt_new;
				OP_TOT:  total_q <= total_new;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				stamp_q <= s_tdata[47:0];
				step_q  <= s_tdata[79:48];
				for (int i = 0; i < WHEELS; i++) begin
					rate_q[i]    <= s_tdata[80 + 32*i +: 32];
					cnt_res_q[i] <= last_q[i];
					spd_res_q[i] <= '0;
				end
				vsp_res_q  <= '0;
				sum_spd_q  <= '0;
				sum_dist_q <= '0;
				used_q     <= '0;
			end
			OP_KA: begin
				opa_q <= {76'd0, cpr_eff};
				opb_q <= {34'd0, INV_TWO_PI};
			end
			OP_KB: begin
				k_q   <= pp_q[49:0];
				opa_q <= {76'd0, cpr_eff};
				opb_q <= {32'd0, step_q};
			end
			OP_KC: cs_q <= pp_q[51:0];
			OP_MUL: pp_q <= a_ch * b_ch;
			OP_ACC: acc_q <= acc_q + ({64'd0, pp_q} << {cmd.sh, 5'd0});
			OP_RATE: begin
				rneg_q <= raw[31];
				opa_q  <= {64'd0, rmag};
				opb_q  <= {32'd0, step_q};
			end
			OP_ANG: begin
				aneg_q <= ang_new[63];
				opa_q  <= {32'd0, ang_mag};
				opb_q  <= {14'd0, k_q};
				acc_q  <= '0;
			end
			OP_CNT: begin
				cnt_res_q[wheel] <= cnt_new;
				dneg_q <= delta49[48];
				opa_q  <= {47'd0, dmag};
				opb_q  <= {32'd0, TWO_PI};
				acc_q  <= '0;
			end
			OP_DSPD: base_q <= acc_q[80:0];
			OP_DSTEP: begin
				nlo_q <= {nlo_q[62:0], 1'b0};
				if (ge) begin
					rem_q <= t65[63:0] - dv_q;
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= t65[63:0];
					quo_q <= {quo_q[62:0], 1'b0};
				end
			end
			OP_SPD: begin
				spd_res_q[wheel] <= spd_new;
				if (sel_w) begin
					sum_spd_q <= sum_spd_q + {{4{spd_new[31]}}, spd_new};
				end
				opa_q <= {15'd0, base_q};
				opb_q <= {46'd0, rad_q};
				acc_q <= '0;
			end
			OP_DIST: begin
				if (sel_w) begin
					sum_dist_q <= sum_dist_q + dist_new;
					used_q     <= used_q + 3'd1;
				end
			end
			OP_MEAN: begin
				opa_q <= {64'd0, quo_q[31:0]};
				opb_q <= {46'd0, rad_q};
			end
			OP_VSPD: vsp_res_q <= vsp_new;
			OP_OUT: begin
				out_data_q <= odata;
				out_user_q <= bad_q;
			end
			default: ;
		endcase
		if (dstart) begin
			dsat_q <= (dn_hi >= dn_d);
			rem_q  <= dn_hi;
			nlo_q  <= dn_lo;
			dv_q   <= dn_d;
			quo_q  <= 64'd0;
		end
	end

	assign sts.bad       = bad_q;
	assign sts.none_used = (used_q == 3'd0);
	assign sts.out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

`default_nettype wire
